// ===== rtl/bpl_pkg.sv =====
// Shared types and constants of the bounded position list.
package bpl_pkg;

   // Largest supported list size, and the width of a position within it.
   localparam int CAP_MAX          = 1024;
   localparam int POS_W            = $clog2(CAP_MAX);
   localparam int DEFAULT_CAPACITY = 64;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] symbol;
   } rec_type;

   typedef enum logic [2:0] {
      FN_INS_HEAD    = 3'd0,
      FN_INS_TAIL    = 3'd1,
      FN_REMOVE_AT   = 3'd2,
      FN_REMOVE_HEAD = 3'd3,
      FN_REMOVE_TAIL = 3'd4,
      FN_CHANGE_AT   = 3'd5,
      FN_READ_AT     = 3'd6,
      FN_READ_TAIL   = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // What every cell does at the next clock edge.
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_UP   = 2'd1,
      CELL_DOWN = 2'd2,
      CELL_LOAD = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [POS_W-1:0]       pos;
      logic [POS_W-1:0]       rd_pos;
      rec_type                rec;
   } cell_ctl_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_READ = 1'b1
   } fsm_state_type;

endpackage

// ===== rtl/bpl_cell.sv =====
// One storage cell of the list, with its stage of the read bus.
module bpl_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  bpl_pkg::cell_ctl_type ctl,
   input  bpl_pkg::rec_type      left_rec,
   input  bpl_pkg::rec_type      right_rec,
   input  bpl_pkg::rec_type      bus_right,
   output bpl_pkg::rec_type      data_out,
   output bpl_pkg::rec_type      bus_out
);
   import bpl_pkg::*;

   localparam logic [POS_W-1:0] MY_INDEX = POS_W'(CELL_INDEX);

   rec_type data_ff;
   rec_type data_in;
   rec_type bus_ff;
   rec_type bus_in;

   always_comb begin
      case (ctl.op)
         CELL_UP:   data_in = left_rec;
         CELL_DOWN: data_in = (MY_INDEX >= ctl.pos) ? right_rec : data_ff;
         CELL_LOAD: data_in = (MY_INDEX == ctl.pos) ? ctl.rec : data_ff;
         default:   data_in = data_ff;
      endcase
   end

   // The selected cell drops its record onto the bus; all others pass the
   // bus on toward cell zero.
   assign bus_in = (MY_INDEX == ctl.rd_pos) ? data_ff : bus_right;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      bus_ff  <= bus_in;
   end

   assign data_out = data_ff;
   assign bus_out  = bus_ff;

endmodule

// ===== rtl/bounded_position_list.sv =====
// Top level of the bounded position list: command decode, cell chain, result register.
//
// An ordered list of up to CAPACITY records (x, y, symbol), held in a row of
// identical cells. Every command transfer on the req_ channel yields exactly
// one transfer on the rsp_ channel carrying a status, the record read (zero
// unless a read succeeded) and the entry count after the command. Inserts,
// removes and overwrites need no wait: every cell loads its own value,
// its left or right neighbor's record or the incoming record, so with rsp_ready
// held high such commands are taken in every cycle. A successful read_at or
// read_tail of position P ties the block up from its transfer to the next
// accepted command, because the record walks down the read bus one cell per
// clock until it reaches cell zero. Failed reads answer without that wait.
// There is no clearing pass after reset: only the control state and count are
// cleared, and no command can read a record that is not live.
module bounded_position_list #(
   parameter int CAPACITY = bpl_pkg::DEFAULT_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [5:0] req_item_index,
   input  logic [7:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic [7:0] req_pos_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_x,
   output logic [7:0] rsp_out_y,
   output logic [7:0] rsp_out_symbol,
   output logic [6:0] rsp_entry_count
);
   import bpl_pkg::*;

   // Count width, and a compare width that also covers the 6-bit index and
   // the 7-bit reported count.
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int WIDE = (CW > 7) ? CW : 7;

   // Control state.
   fsm_state_type    state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    wait_ff, wait_in;
   logic [POS_W-1:0] rd_pos_ff, rd_pos_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Result register payload.
   status_type       status_ff, status_in;
   rec_type          out_rec_ff, out_rec_in;
   logic [CW-1:0]    out_count_ff, out_count_in;

   logic             accept;
   logic             out_free;
   logic             rsp_load;
   logic [WIDE-1:0]  count_ext;
   logic [WIDE-1:0]  idx_ext;
   logic             is_full;
   logic             is_empty;
   logic             out_range;
   func_type         func;
   rec_type          new_rec;
   cell_op_type      dec_op;
   logic [POS_W-1:0] dec_pos;
   status_type       dec_status;
   logic [CW-1:0]    dec_count;
   logic             dec_read;
   logic [POS_W-1:0] dec_rd_pos;
   cell_ctl_type     ctl;

   rec_type          cell_data [CAPACITY];
   rec_type          bus_chain [CAPACITY+1];

   assign func      = func_type'(req_func);
   assign new_rec   = '{x: req_pos_x, y: req_pos_y, symbol: req_pos_symbol};
   assign count_ext = WIDE'(count_ff);
   assign idx_ext   = WIDE'(req_item_index);
   assign is_full   = count_ext >= WIDE'(CAPACITY);
   assign is_empty  = (count_ff == '0);
   assign out_range = idx_ext >= count_ext;

   // The result register is free when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == FSM_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // Command decode: status, count after the command, and cell action.
   always_comb begin
      dec_op     = CELL_HOLD;
      dec_pos    = '0;
      dec_status = ST_OK;
      dec_count  = count_ff;
      dec_read   = 1'b0;
      dec_rd_pos = POS_W'(req_item_index);
      case (func)
         FN_INS_HEAD: begin
            if (is_full) begin
               dec_status = ST_FULL;
            end else begin
               dec_op    = CELL_UP;
               dec_count = count_ff + CW'(1);
            end
         end
         FN_INS_TAIL: begin
            if (is_full) begin
               dec_status = ST_FULL;
            end else begin
               dec_op    = CELL_LOAD;
               dec_pos   = POS_W'(count_ff);
               dec_count = count_ff + CW'(1);
            end
         end
         FN_REMOVE_AT: begin
            if (out_range) begin
               dec_status = ST_RANGE;
            end else begin
               dec_op    = CELL_DOWN;
               dec_pos   = POS_W'(req_item_index);
               dec_count = count_ff - CW'(1);
            end
         end
         FN_REMOVE_HEAD: begin
            if (is_empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_op    = CELL_DOWN;
               dec_count = count_ff - CW'(1);
            end
         end
         FN_REMOVE_TAIL: begin
            if (is_empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_count = count_ff - CW'(1);
            end
         end
         FN_CHANGE_AT: begin
            if (out_range) begin
               dec_status = ST_RANGE;
            end else begin
               dec_op  = CELL_LOAD;
               dec_pos = POS_W'(req_item_index);
            end
         end
         FN_READ_AT: begin
            if (out_range) begin
               dec_status = ST_RANGE;
            end else begin
               dec_read = 1'b1;
            end
         end
         FN_READ_TAIL: begin
            if (is_empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_read   = 1'b1;
               dec_rd_pos = POS_W'(count_ff - CW'(1));
            end
         end
         default: begin
            dec_status = ST_OK;
         end
      endcase
   end

   // Broadcast to the cells; nothing moves unless a command is taken.
   assign ctl = '{op:     accept ? dec_op : CELL_HOLD,
                  pos:    dec_pos,
                  rd_pos: rd_pos_ff,
                  rec:    new_rec};

   // Sequencer: a successful read waits for the record to reach cell zero.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      wait_in      = wait_ff;
      rd_pos_in    = rd_pos_ff;
      rsp_load     = 1'b0;
      status_in    = status_ff;
      out_rec_in   = out_rec_ff;
      out_count_in = out_count_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               count_in = dec_count;
               if (dec_read) begin
                  state_in  = FSM_READ;
                  rd_pos_in = dec_rd_pos;
                  wait_in   = CW'(dec_rd_pos) + CW'(1);
               end else begin
                  rsp_load     = 1'b1;
                  status_in    = dec_status;
                  out_rec_in   = '0;
                  out_count_in = dec_count;
               end
            end
         end
         FSM_READ: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - CW'(1);
            end else if (out_free) begin
               state_in     = FSM_IDLE;
               rsp_load     = 1'b1;
               status_in    = ST_OK;
               out_rec_in   = bus_chain[0];
               out_count_in = count_ff;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rd_pos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rd_pos_ff    <= rd_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      out_rec_ff   <= out_rec_in;
      out_count_ff <= out_count_in;
   end

   // The cell chain. Cell zero takes the new record on a head insert, and
   // the end of the read bus feeds zeros.
   assign bus_chain[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      rec_type left_rec;
      rec_type right_rec;
      if (i == 0) begin : g_first
         assign left_rec = new_rec;
      end else begin : g_inner
         assign left_rec = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_rec = '0;
      end else begin : g_mid
         assign right_rec = cell_data[i+1];
      end
      bpl_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .bus_right (bus_chain[i+1]),
         .data_out  (cell_data[i]),
         .bus_out   (bus_chain[i])
      );
   end

   logic [WIDE-1:0] out_count_ext;
   assign out_count_ext   = WIDE'(out_count_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_x       = out_rec_ff.x;
   assign rsp_out_y       = out_rec_ff.y;
   assign rsp_out_symbol  = out_rec_ff.symbol;
   assign rsp_entry_count = out_count_ext[6:0];

   // The live count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      WIDE'(count_ff) <= WIDE'(CAPACITY))
      else $error("entry count exceeds capacity");

   // No command is taken while a read walks down the chain.
   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_READ) |-> !req_ready)
      else $error("command accepted during a read");

   // The count only moves when a command is taken.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("count changed without a command");

   // A finished read always reports success with the count unchanged.
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_READ && rsp_load) |=>
         (rsp_valid && rsp_status == ST_OK && out_count_ff == count_ff))
      else $error("read result malformed");

endmodule

// ===== tb/bounded_position_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bounded position list: predicts every response and compares it.
module bounded_position_list_checker #(
   parameter int CAPACITY = bpl_pkg::DEFAULT_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [5:0] req_item_index,
   input  logic [7:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic [7:0] req_pos_symbol,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_status,
   input  logic [7:0] rsp_out_x,
   input  logic [7:0] rsp_out_y,
   input  logic [7:0] rsp_out_symbol,
   input  logic [6:0] rsp_entry_count,
   output int         mismatch_count,
   output int         answers_owed
);
   import bpl_pkg::*;

   typedef struct packed {
      status_type status;
      rec_type    rec;
      logic [6:0] count;
   } answer_type;

   rec_type    shadow_list [CAPACITY];
   int         shadow_count;
   answer_type owed_answers [$];
   int         failures;

   // Applies one command to the shadow list and returns the response it should give.
   function automatic answer_type apply_list_command(func_type fn, logic [5:0] idx,
                                                     rec_type wr);
      answer_type ans;
      int         i;
      int         at;
      ans.status = ST_OK;
      ans.rec    = '0;
      at         = int'(idx);
      case (fn)
         FN_INS_HEAD: begin
            if (shadow_count >= CAPACITY) begin
               ans.status = ST_FULL;
            end else begin
               for (i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[0] = wr;
               shadow_count++;
            end
         end
         FN_INS_TAIL: begin
            if (shadow_count >= CAPACITY) begin
               ans.status = ST_FULL;
            end else begin
               shadow_list[shadow_count] = wr;
               shadow_count++;
            end
         end
         FN_REMOVE_AT: begin
            if (at >= shadow_count) begin
               ans.status = ST_RANGE;
            end else begin
               for (i = at; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
               shadow_count--;
            end
         end
         FN_REMOVE_HEAD: begin
            if (shadow_count == 0) begin
               ans.status = ST_EMPTY;
            end else begin
               for (i = 0; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
               shadow_count--;
            end
         end
         FN_REMOVE_TAIL: begin
            if (shadow_count == 0) ans.status = ST_EMPTY;
            else shadow_count--;
         end
         FN_CHANGE_AT: begin
            if (at >= shadow_count) ans.status = ST_RANGE;
            else shadow_list[at] = wr;
         end
         FN_READ_AT: begin
            if (at >= shadow_count) ans.status = ST_RANGE;
            else ans.rec = shadow_list[at];
         end
         default: begin
            if (shadow_count == 0) ans.status = ST_EMPTY;
            else ans.rec = shadow_list[shadow_count-1];
         end
      endcase
      ans.count = shadow_count[6:0];
      return ans;
   endfunction

   always @(posedge clock) begin : watch_channels
      answer_type want;
      if (reset) begin
         shadow_count = 0;
         owed_answers.delete();
      end else begin
         // Push before pop, so the front is always the oldest command.
         if (req_valid && req_ready) begin
            owed_answers.push_back(apply_list_command(func_type'(req_func), req_item_index,
               rec_type'({req_pos_x, req_pos_y, req_pos_symbol})));
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_answers.size() == 0) begin
               if (failures < 10)
                  $display("unexpected response: status %0d x %02h y %02h sym %02h count %0d",
                           rsp_status, rsp_out_x, rsp_out_y, rsp_out_symbol, rsp_entry_count);
               failures++;
            end else begin
               want = owed_answers.pop_front();
               if (rsp_status !== want.status || rsp_out_x !== want.rec.x ||
                   rsp_out_y !== want.rec.y || rsp_out_symbol !== want.rec.symbol ||
                   rsp_entry_count !== want.count) begin
                  if (failures < 10) begin
                     $display("response wrong at %0t: expected status %0d x %02h y %02h",
                              $realtime, want.status, want.rec.x, want.rec.y);
                     $display("   expected sym %02h count %0d", want.rec.symbol, want.count);
                     $display("   got status %0d x %02h y %02h sym %02h count %0d",
                              rsp_status, rsp_out_x, rsp_out_y, rsp_out_symbol,
                              rsp_entry_count);
                  end
                  failures++;
               end
            end
         end
      end
      mismatch_count <= failures;
      answers_owed   <= owed_answers.size();
   end

endmodule

// ===== tb/bounded_position_list_test.sv =====
`timescale 1ns / 1ps
// Top of the bounded position list testbench: clock, reset, command stimulus and verdict.
module bounded_position_list_test;
   import bpl_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int IDLE_PERCENT = 27;
   // A read of the last position holds the block longest.
   localparam int SETTLE_CYCLES = CAPACITY + 8;
   // Worst case is roughly 450 commands, each a deep read plus stalls on both sides,
   // and the limit leaves a wide margin over that.
   localparam int CYCLE_LIMIT = 400000;

   // Each random round walks the list from empty to full and back again, so that
   // the full and empty conditions are reached with live contents in between.
   typedef enum {PHASE_FILL, PHASE_MIX, PHASE_DRAIN} phase_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [2:0] req_func       = '0;
   logic [5:0] req_item_index = '0;
   logic [7:0] req_pos_x      = '0;
   logic [7:0] req_pos_y      = '0;
   logic [7:0] req_pos_symbol = '0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_out_x;
   logic [7:0] rsp_out_y;
   logic [7:0] rsp_out_symbol;
   logic [6:0] rsp_entry_count;

   // While steady is high neither side idles, which gives back-to-back transfers.
   logic       steady = 1'b0;
   int         mismatch_count;
   int         answers_owed;
   int         cycle_count = 0;

   bounded_position_list #(.CAPACITY(CAPACITY)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_item_index  (req_item_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_symbol  (req_pos_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_symbol  (rsp_out_symbol),
      .rsp_entry_count (rsp_entry_count)
   );

   bounded_position_list_checker #(.CAPACITY(CAPACITY)) list_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_item_index  (req_item_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_symbol  (req_pos_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_symbol  (rsp_out_symbol),
      .rsp_entry_count (rsp_entry_count),
      .mismatch_count  (mismatch_count),
      .answers_owed    (answers_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The response side stalls at random, except during the steady stretch. The same
   // process keeps the cycle count and ends a run that has hung.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready   <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Presents one command and returns at the edge where its transfer happens. Idle
   // cycles are inserted ahead of the command at random; once valid rises it stays
   // high with the payload held until ready is seen at an edge.
   task automatic issue_command(input func_type fn, input logic [5:0] idx,
                                input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] sym);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= fn;
      req_item_index <= idx;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_pos_symbol <= sym;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Issues a run of random commands whose mix suits the phase. Half the indexes
   // are kept small so that indexed commands usually land on live entries, while
   // the rest cover the whole index field and can produce range errors.
   task automatic run_phase(input phase_type ph, input int count);
      func_type   fn;
      logic [5:0] idx;
      int         pick;
      int         n;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         fn   = func_type'($urandom_range(0, 7));
         if (ph == PHASE_FILL && pick < 95) begin
            fn = (pick % 2 == 0) ? FN_INS_HEAD : FN_INS_TAIL;
         end else if (ph == PHASE_DRAIN && pick < 95) begin
            case (pick % 3)
               0:       fn = FN_REMOVE_AT;
               1:       fn = FN_REMOVE_HEAD;
               default: fn = FN_REMOVE_TAIL;
            endcase
         end
         if ($urandom_range(0, 1) == 1) idx = 6'($urandom_range(0, 7));
         else idx = 6'($urandom_range(0, 63));
         issue_command(fn, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      int round;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Every read, remove and overwrite command against the empty list: empty and range errors, no data.
      issue_command(FN_READ_TAIL,   6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_READ_AT,     6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_REMOVE_HEAD, 6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_REMOVE_TAIL, 6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_REMOVE_AT,   6'd0,  8'hFF, 8'hFF, 8'hFF);
      issue_command(FN_CHANGE_AT,   6'd0,  8'hFF, 8'hFF, 8'hFF);
      // Build a short list with extreme field values, inserting at both ends.
      issue_command(FN_INS_TAIL,    6'd63, 8'hFF, 8'hFF, 8'hFF);
      issue_command(FN_INS_HEAD,    6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_INS_HEAD,    6'd0,  8'hA5, 8'h5A, 8'h3C);
      issue_command(FN_INS_TAIL,    6'd0,  8'h01, 8'h02, 8'h03);
      // Reads at both ends, just past the count and at the top of the index field.
      issue_command(FN_READ_AT,     6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_READ_AT,     6'd3,  8'h00, 8'h00, 8'h00);
      issue_command(FN_READ_AT,     6'd4,  8'h00, 8'h00, 8'h00);
      issue_command(FN_READ_AT,     6'd63, 8'h00, 8'h00, 8'h00);
      issue_command(FN_READ_TAIL,   6'd0,  8'h00, 8'h00, 8'h00);
      // Overwrite in the middle, then remove from the middle and both ends.
      issue_command(FN_CHANGE_AT,   6'd2,  8'h80, 8'h7F, 8'hFF);
      issue_command(FN_READ_AT,     6'd2,  8'h00, 8'h00, 8'h00);
      issue_command(FN_REMOVE_AT,   6'd1,  8'h00, 8'h00, 8'h00);
      issue_command(FN_READ_AT,     6'd1,  8'h00, 8'h00, 8'h00);
      issue_command(FN_REMOVE_HEAD, 6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_REMOVE_TAIL, 6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_READ_TAIL,   6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_REMOVE_AT,   6'd0,  8'h00, 8'h00, 8'h00);
      // The list is empty again; both of these must report it.
      issue_command(FN_REMOVE_TAIL, 6'd0,  8'h00, 8'h00, 8'h00);
      issue_command(FN_READ_TAIL,   6'd0,  8'h00, 8'h00, 8'h00);

      // Two rounds of fill, mix, drain, mix. The second fill runs with no idling
      // on either side so the inserts and the full responses go back to back.
      for (round = 0; round < 2; round++) begin
         steady <= (round == 1);
         run_phase(PHASE_FILL, 70);
         steady <= 1'b0;
         run_phase(PHASE_MIX, 50);
         run_phase(PHASE_DRAIN, 70);
         run_phase(PHASE_MIX, 35);
      end
      req_valid <= 1'b0;

      // The owed count is registered behind the transfers, so step once before waiting.
      @(posedge clock);
      while (answers_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && answers_owed == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
